// ===== rtl/crcrs_pkg.sv =====
// Shared constants, kinds and helpers of the CRC-checked register slave.
package crcrs_pkg;

  localparam int FRAME_MAX   = 16;
  localparam int STORE_DEPTH = 32;

  localparam int LEN_W  = $clog2(FRAME_MAX + 2);
  localparam int BUF_AW = $clog2(FRAME_MAX);
  localparam int ST_AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] MARK_BYTE = 8'hFF;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_CRC    = 2'd1;
  localparam logic [1:0] ERR_UNINIT = 2'd2;
  localparam logic [1:0] ERR_OTHER  = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  function automatic logic [7:0] err_code(input logic [1:0] err);
    logic [7:0] code;
    case (err)
      ERR_OK:     code = 8'h00;
      ERR_CRC:    code = 8'hFF;
      ERR_UNINIT: code = 8'hFD;
      ERR_OTHER:  code = 8'hFE;
      default:    code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/crc_checked_register_slave_unit.sv =====
// Top level: write frames are buffered and CRC-checked, reads return data and check bytes.
// Write item: one load, then eight bit steps of the shared CRC shifter; a frame end with a
//   good CRC adds a commit sweep (address and write states) for each buffered byte but the last.
// Read item: a due check or marker byte goes straight to the result register, else a store
//   read and a CRC of the data byte, plus any wait for the result register to empty.
// One item at a time; the result register lets the next item in while a result waits.
// Synchronous active-low reset; store entries read as zero until first written.
module crc_checked_register_slave_unit import crcrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tlast,   // frame_end
  input  logic       in_tuser,   // [0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic [1:0] out_tuser   // [1:0] byte_kind
);

  typedef enum logic [2:0] {
    S_IDLE, S_CRC, S_CADDR, S_CWR, S_RD, S_RDAT, S_EMIT
  } state_t;

  state_t            state_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  cidx_r;
  logic [7:0]        run_crc_r;
  logic [7:0]        crc_work_r;
  logic [7:0]        crc_nxt;
  logic [2:0]        cnt_r;
  logic              crc_rd_r;
  logic              fend_r;
  logic [7:0]        ptr_r;
  logic [1:0]        err_r;
  logic              pend_r;
  logic [7:0]        pend_byte_r;
  logic [7:0]        res_byte_r;
  logic [1:0]        res_kind_r;
  logic              out_tvalid_r;
  logic [7:0]        out_tdata_r;
  logic [1:0]        out_tuser_r;

  logic [7:0]        buf_mem [FRAME_MAX];
  logic [7:0]        buf_q_r;
  logic [7:0]        st_mem [STORE_DEPTH];
  logic [7:0]        st_q_r;
  logic [STORE_DEPTH-1:0] st_vld_r;

  logic              in_acc;
  logic              buf_we;
  logic              ptr_in_range;
  logic              st_we;
  logic              len_ok;
  logic [7:0]        rd_data;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Shared CRC-8 unit: one bit per cycle, MSB first
  assign crc_nxt = crc_work_r[7] ? ({crc_work_r[6:0], 1'b0} ^ CRC_POLY)
                                 : {crc_work_r[6:0], 1'b0};

  assign buf_we       = in_acc && (in_tuser == MODE_WRITE) && (len_r < LEN_W'(FRAME_MAX));
  assign ptr_in_range = ({1'b0, ptr_r} < 9'(STORE_DEPTH));
  assign st_we        = (state_r == S_CWR) && (cidx_r != '0) && ptr_in_range;
  assign len_ok       = (len_r >= LEN_W'(2)) && (len_r <= LEN_W'(FRAME_MAX));
  assign rd_data      = (ptr_in_range && st_vld_r[ptr_r[ST_AW-1:0]]) ? st_q_r : 8'h00;

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[len_r[BUF_AW-1:0]] <= in_tdata;
    end
    buf_q_r <= buf_mem[cidx_r[BUF_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[ptr_r[ST_AW-1:0]] <= buf_q_r;
    end
    st_q_r <= st_mem[ptr_r[ST_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
    end else if (st_we) begin
      st_vld_r[ptr_r[ST_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= '0;
      cidx_r       <= '0;
      run_crc_r    <= '0;
      cnt_r        <= '0;
      crc_rd_r     <= 1'b0;
      fend_r       <= 1'b0;
      ptr_r        <= '0;
      err_r        <= ERR_UNINIT;
      pend_r       <= 1'b0;
      pend_byte_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready && (state_r != S_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser == MODE_WRITE) begin
              if (len_r <= LEN_W'(FRAME_MAX)) begin
                len_r <= len_r + 1'b1;
              end
              crc_work_r <= run_crc_r ^ in_tdata;
              cnt_r      <= '0;
              crc_rd_r   <= 1'b0;
              fend_r     <= in_tlast;
              state_r    <= S_CRC;
            end else if (pend_r) begin
              pend_r     <= 1'b0;
              res_byte_r <= pend_byte_r;
              res_kind_r <= KIND_CHECK;
              state_r    <= S_EMIT;
            end else if (err_r != ERR_OK) begin
              pend_byte_r <= err_code(err_r);
              pend_r      <= 1'b1;
              res_byte_r  <= MARK_BYTE;
              res_kind_r  <= KIND_MARK;
              state_r     <= S_EMIT;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_CRC: begin
          crc_work_r <= crc_nxt;
          cnt_r      <= cnt_r + 1'b1;
          if (cnt_r == 3'd7) begin
            if (crc_rd_r) begin
              pend_byte_r <= crc_nxt;
              pend_r      <= 1'b1;
              state_r     <= S_EMIT;
            end else if (!fend_r) begin
              run_crc_r <= crc_nxt;
              state_r   <= S_IDLE;
            end else begin
              run_crc_r <= '0;
              state_r   <= S_IDLE;
              if (!len_ok) begin
                len_r <= '0;
              end else if (crc_nxt != 8'h00) begin
                err_r <= ERR_CRC;
                len_r <= '0;
              end else begin
                err_r   <= ERR_OK;
                pend_r  <= 1'b0;
                cidx_r  <= '0;
                state_r <= S_CADDR;
              end
            end
          end
        end
        S_CADDR: begin
          state_r <= S_CWR;
        end
        S_CWR: begin
          // first buffered byte is the pointer, the rest but the last (check byte) are data
          if (cidx_r == '0) begin
            ptr_r <= buf_q_r;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
          cidx_r <= cidx_r + 1'b1;
          if (cidx_r == LEN_W'(len_r - 1'b1) - 1'b1) begin
            len_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_CADDR;
          end
        end
        S_RD: begin
          state_r <= S_RDAT;
        end
        S_RDAT: begin
          res_byte_r <= rd_data;
          res_kind_r <= KIND_DATA;
          crc_work_r <= rd_data;
          cnt_r      <= '0;
          crc_rd_r   <= 1'b1;
          ptr_r      <= ptr_r + 1'b1;
          state_r    <= S_CRC;
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= res_byte_r;
            out_tuser_r  <= res_kind_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/crcrs_checker.sv =====
// Port-level checks of the CRC-checked register slave, bound to the top level.
module crcrs_checker import crcrs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a write item keeps the CRC shifter busy for the following cycle
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_WRITE) |=> !in_tready)
    else $error("ready during CRC of a write item");

  a_mark_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_MARK) |-> out_tdata == MARK_BYTE)
    else $error("error marker is not 0xFF");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("unknown byte kind");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind crc_checked_register_slave_unit crcrs_checker u_crcrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/crc_checked_register_slave_unit_tb.sv =====
// Self-checking testbench for the CRC-checked register slave: directed frames and reads, then random traffic.
module crc_checked_register_slave_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crcrs_pkg::*;

  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 400;
  localparam int TAIL_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic       mode;
    logic [7:0] rx;
    logic       fend;
    bit         drain;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] tx;
    logic [1:0] kind;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;

  bus_item_t  bus_items[$];
  bus_item_t  cur_item;
  reply_t     due_replies[$];
  logic [7:0] frame_bytes[$];

  // predicted slave state
  logic [7:0] m_fb [FRAME_MAX];
  int         m_flen;
  logic [7:0] m_crc;
  logic [7:0] m_ptr;
  logic [1:0] m_err;
  logic       m_chk_due;
  logic [7:0] m_chk_byte;
  logic [7:0] m_store [STORE_DEPTH];

  int n_sent = 0, exp_cnt = 0, got_cnt = 0, n_fail = 0, cycle_cnt = 0;
  int n_commit = 0, n_crc_bad = 0, n_len_rej = 0;
  int n_data = 0, n_check = 0, n_mark = 0;
  int hold_cycles = 0;
  logic hold_active = 1'b0, hold_done = 1'b0;

  crc_checked_register_slave_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] crc8_byte(logic [7:0] acc, logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [7:0] err_byte(logic [1:0] err);
    logic [7:0] code;
    case (err)
      ERR_OK:     code = 8'h00;
      ERR_CRC:    code = 8'hFF;
      ERR_UNINIT: code = 8'hFD;
      default:    code = 8'hFE;
    endcase
    return code;
  endfunction

  function automatic void slave_reset();
    foreach (m_fb[i]) m_fb[i] = 8'h00;
    foreach (m_store[i]) m_store[i] = 8'h00;
    m_flen     = 0;
    m_crc      = 8'h00;
    m_ptr      = 8'h00;
    m_err      = ERR_UNINIT;
    m_chk_due  = 1'b0;
    m_chk_byte = 8'h00;
  endfunction

  // Advances the predicted state by one accepted item; returns replies queued.
  function automatic int track_slave_item(bus_item_t it);
    logic [7:0] data;
    if (it.mode == MODE_WRITE) begin
      if (m_flen < FRAME_MAX) m_fb[m_flen] = it.rx;
      if (m_flen <= FRAME_MAX) m_flen++;
      m_crc = crc8_byte(m_crc, it.rx);
      if (it.fend) begin
        if (m_flen < 2 || m_flen > FRAME_MAX) begin
          n_len_rej++;
        end else if (m_crc != 8'h00) begin
          m_err = ERR_CRC;
          n_crc_bad++;
        end else begin
          m_err     = ERR_OK;
          m_chk_due = 1'b0;
          m_ptr     = m_fb[0];
          for (int i = 1; i + 1 < m_flen; i++) begin
            if (int'(m_ptr) < STORE_DEPTH) m_store[int'(m_ptr)] = m_fb[i];
            m_ptr++;
          end
          n_commit++;
        end
        m_flen = 0;
        m_crc  = 8'h00;
      end
      return 0;
    end
    if (m_chk_due) begin
      m_chk_due = 1'b0;
      due_replies.push_back({m_chk_byte, KIND_CHECK});
    end else if (m_err != ERR_OK) begin
      m_chk_byte = err_byte(m_err);
      m_chk_due  = 1'b1;
      due_replies.push_back({MARK_BYTE, KIND_MARK});
    end else begin
      data = (int'(m_ptr) < STORE_DEPTH) ? m_store[int'(m_ptr)] : 8'h00;
      m_chk_byte = crc8_byte(8'h00, data);
      m_chk_due  = 1'b1;
      m_ptr++;
      due_replies.push_back({data, KIND_DATA});
    end
    return 1;
  endfunction

  task automatic queue_item(logic mode, logic [7:0] rx, logic fend, bit drain);
    bus_item_t it;
    it.mode  = mode;
    it.rx    = rx;
    it.fend  = fend;
    it.drain = drain;
    bus_items.push_back(it);
  endtask

  task automatic queue_reads(int n, bit drain);
    for (int i = 0; i < n; i++)
      queue_item(MODE_READ, 8'($urandom), 1'($urandom), drain && i == 0);
  endtask

  // Sends frame_bytes followed by their check byte, optionally with one byte damaged.
  task automatic queue_frame(bit corrupt);
    logic [7:0] chk;
    int         bad_at;
    chk = 8'h00;
    foreach (frame_bytes[i]) chk = crc8_byte(chk, frame_bytes[i]);
    frame_bytes.push_back(chk);
    if (corrupt) begin
      bad_at = $urandom_range(frame_bytes.size() - 1);
      frame_bytes[bad_at] ^= 8'($urandom_range(1, 255));
    end
    foreach (frame_bytes[i])
      queue_item(MODE_WRITE, frame_bytes[i], i == frame_bytes.size() - 1, 1'b0);
    frame_bytes.delete();
  endtask

  task automatic queue_random_frame(bit corrupt);
    int n;
    frame_bytes.push_back(($urandom_range(99) < 75) ? 8'($urandom_range(STORE_DEPTH + 2))
                                                    : 8'($urandom));
    n = ($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(5, FRAME_MAX - 2);
    repeat (n) frame_bytes.push_back(8'($urandom));
    queue_frame(corrupt);
  endtask

  task automatic report_mismatch(reply_t want, logic [7:0] tx, logic [1:0] kind);
    n_fail++;
    if (n_fail <= MAX_REPORTS)
      $display("mismatch at %0t: expected tx %02h kind %0d, got tx %02h kind %0d",
               $time, want.tx, want.kind, tx, kind);
  endtask

  // Driver
  always @(posedge clk) begin
    int  pushed;
    bit  idle;
    pushed = 0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pushed = track_slave_item(cur_item);
        n_sent <= n_sent + 1;
      end
      exp_cnt <= exp_cnt + pushed;
      if (!in_tvalid || in_tready) begin
        idle = ($urandom_range(99) < IDLE_PCT) && !(n_sent >= 120 && n_sent < 220);
        if (bus_items.size() == 0 || idle ||
            (bus_items[0].drain && (in_tvalid || exp_cnt != got_cnt))) begin
          in_tvalid <= 1'b0;
        end else begin
          cur_item = bus_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_item.mode;
          in_tdata  <= cur_item.rx;
          in_tlast  <= cur_item.fend;
        end
      end
    end
  end

  // Long receiver hold-off once traffic is well under way
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_active <= 1'b0;
      hold_done   <= 1'b0;
      hold_cycles <= 0;
    end else if (!hold_done && !hold_active && n_sent >= HOLD_AT) begin
      hold_active <= 1'b1;
      hold_cycles <= 0;
    end else if (hold_active) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) begin
        hold_active <= 1'b0;
        hold_done   <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_cnt <= got_cnt + 1;
        case (out_tuser)
          KIND_DATA:  n_data++;
          KIND_CHECK: n_check++;
          default:    n_mark++;
        endcase
        if (due_replies.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("unexpected reply at %0t: tx %02h kind %0d", $time, out_tdata, out_tuser);
        end else begin
          want = due_replies.pop_front();
          if (out_tdata !== want.tx || out_tuser !== want.kind)
            report_mismatch(want, out_tdata, out_tuser);
        end
      end
      if (hold_active)
        out_tready <= 1'b0;
      else if (got_cnt >= 40 && got_cnt < 90)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_cnt,
               due_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int target;
    int pick;
    bit first_burst;
    slave_reset();

    // directed: reset error marker, bounds of the store, bad/short frames, dropped check
    queue_reads(2, 1'b0);
    frame_bytes = '{8'd30, 8'hA5, 8'h00, 8'hFF};
    queue_frame(1'b0);
    queue_reads(2, 1'b0);
    queue_item(MODE_WRITE, 8'hFF, 1'b1, 1'b0);
    frame_bytes = '{8'h00, 8'h3C};
    queue_frame(1'b1);
    queue_reads(2, 1'b0);
    frame_bytes = '{8'd31};
    queue_frame(1'b0);
    queue_reads(1, 1'b0);
    frame_bytes = '{8'hFF};
    queue_frame(1'b0);
    queue_reads(3, 1'b0);

    target = bus_items.size() + RANDOM_ITEMS;
    first_burst = 1'b1;
    while (bus_items.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        queue_random_frame(1'b0);
      end else if (pick < 48) begin
        queue_random_frame(1'b1);
      end else if (pick < 52) begin
        queue_item(MODE_WRITE, 8'($urandom), 1'b1, 1'b0);
      end else if (pick < 55) begin
        // overlong frame, sometimes with a valid check so only the length rejects it
        repeat ($urandom_range(FRAME_MAX, FRAME_MAX + 3)) frame_bytes.push_back(8'($urandom));
        if ($urandom_range(1)) begin
          queue_frame(1'b0);
        end else begin
          frame_bytes.push_back(8'($urandom));
          foreach (frame_bytes[i])
            queue_item(MODE_WRITE, frame_bytes[i], i == frame_bytes.size() - 1, 1'b0);
          frame_bytes.delete();
        end
      end else if (pick < 60) begin
        pick = $urandom_range(1, 4);
        for (int i = 0; i < pick; i++)
          queue_item(MODE_WRITE, 8'($urandom), (i == pick - 1) || ($urandom_range(99) < 30),
                     1'b0);
      end else begin
        queue_reads($urandom_range(1, 8), first_burst || ($urandom_range(99) < 3));
        first_burst = 1'b0;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (bus_items.size() != 0 || in_tvalid || due_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items accepted, %0d replies checked (%0d data, %0d check, %0d marker)",
             n_sent, got_cnt, n_data, n_check, n_mark);
    $display("frames: %0d committed, %0d CRC errors, %0d length rejects; %0d failures",
             n_commit, n_crc_bad, n_len_rej, n_fail);
    if (n_fail == 0 && due_replies.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/crcrs_pkg.sv
rtl/crc_checked_register_slave_unit.sv
rtl/crcrs_checker.sv
tb/sv/crc_checked_register_slave_unit_tb.sv
